// File: design/nbge_pkg.sv
package nbge_pkg;

	localparam int IN_DATA_W  = 320;
	localparam int OUT_DATA_W = 264;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BODY_COUNT = 1'b0,
		REG_TIME_STEP  = 1'b1
	} cfg_reg_t;

	localparam logic MODE_LOAD = 1'b0;

endpackage

// File: design/nbody_gravity_euler_step.sv
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | tuser: mode; tdata: body_index, grav_param, pos, vel
// m_      | out | m_tvalid/m_tready | tdata: out_index, new pos, new vel; tlast: last_body
// cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
//
// A step visits every ordered pair of the N bodies, then updates each body's velocity and
// position; all pairs share one bit-serial multiplier, square root and divider. Each pair
// is normalized, then runs the multiply and root steps and two divisions; a coincident
// pair is skipped. s_tready is high only while idle; a low m_tready holds the result
// and the whole sequencer.
// Reset clears the body table through per-slot valid bits.
module nbody_gravity_euler_step #(
	parameter int MAX_BODIES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [3:0] body_index, [59:4] grav_param, [123:60] pos_x, [187:124] pos_y,
	// [251:188] vel_x, [315:252] vel_y
	input  logic [nbge_pkg::IN_DATA_W-1:0]       s_tdata,
	// [0] mode
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [3:0] out_index, [67:4] new_pos_x, [131:68] new_pos_y, [195:132] new_vel_x,
	// [259:196] new_vel_y
	output logic [nbge_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	input  logic                                 cfg_we,
	input  logic [nbge_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nbge_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam int CW = $clog2(MAX_BODIES + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_A_RDI, S_A_LDI, S_A_SELJ, S_A_RDJ, S_A_DIFF, S_NORM, S_SQ1, S_SQ2,
		S_SQRT, S_R2, S_R3, S_MULG, S_DIV, S_ACC, S_A_WR, S_B_RD, S_B_LD, S_MVX, S_MVY,
		S_MPX, S_MPY, S_B_OUT, S_B_WAIT
	} state_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] t;
		t = {a[63], a} + {b[63], b};
		if (t[64] != t[63])
			return t[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		return t[63:0];
	endfunction

	function automatic logic [63:0] with_sign(input logic [63:0] m, input logic neg);
		return neg ? (64'd0 - m) : m;
	endfunction

	function automatic logic [63:0] absv(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	state_t        state_q;
	logic [CW-1:0] i_q, j_q, count_c;
	logic          axis_q, m_tvalid_q;
	logic [4:0]    body_count_q;
	logic [15:0]   time_step_q;
	logic [MAX_BODIES-1:0] valid_q;

	logic [55:0] body_gm_q [MAX_BODIES];
	logic [63:0] body_px_q [MAX_BODIES];
	logic [63:0] body_py_q [MAX_BODIES];
	logic [63:0] body_vx_q [MAX_BODIES];
	logic [63:0] body_vy_q [MAX_BODIES];
	logic [63:0] accel_x_q [MAX_BODIES];
	logic [63:0] accel_y_q [MAX_BODIES];

	logic [55:0] rd_gm_q;
	logic [63:0] rd_px_q, rd_py_q, rd_vx_q, rd_vy_q, rd_ax_q, rd_ay_q;
	logic        rd_vld_q;
	logic [55:0] rgm;
	logic [63:0] rpx, rpy, rvx, rvy;

	logic [63:0] pix_q, piy_q, ux_q, uy_q, sv_q, res_q, bit_q, q_q;
	logic [63:0] accx_q, accy_q, vx_q, vy_q, px_q, py_q, ax_q, ay_q;
	logic [55:0] gm_q;
	logic        nx_q, ny_q, ovf_q;
	logic [5:0]  s_q;
	logic [95:0] ma_q, acc_q, d_q, rem_q;
	logic [31:0] mb_q, r_q;
	logic [7:0]  cnt_q;
	logic [86:0] pd_q;

	logic [IW-1:0] rd_addr, wr_addr;
	logic          ld_acc, wr_body, last_c, mul_last, norm_go, pair_zero;
	logic [95:0]   acc_nxt;
	logic [64:0]   dx65, dy65;
	logic [63:0]   mx, my, tr, sv_nxt, res_nxt, q_mag, term;
	logic          sq_ge, div_ge;
	logic [96:0]   remsh;
	logic [95:0]   rem_nxt;

	assign count_c = (32'(body_count_q) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(body_count_q);
	assign last_c  = (CW'(i_q + 1'b1) == count_c);
	assign ld_acc  = s_tvalid && s_tready && (s_tuser == nbge_pkg::MODE_LOAD)
		&& (32'(s_tdata[3:0]) < MAX_BODIES);
	assign wr_body = ld_acc || (state_q == S_B_OUT);
	assign wr_addr = (state_q == S_IDLE) ? IW'(s_tdata[3:0]) : i_q[IW-1:0];
	assign rd_addr = (state_q == S_A_RDJ) ? j_q[IW-1:0] : i_q[IW-1:0];

	assign rgm = rd_vld_q ? rd_gm_q : '0;
	assign rpx = rd_vld_q ? rd_px_q : '0;
	assign rpy = rd_vld_q ? rd_py_q : '0;
	assign rvx = rd_vld_q ? rd_vx_q : '0;
	assign rvy = rd_vld_q ? rd_vy_q : '0;

	assign dx65      = {rpx[63], rpx} - {pix_q[63], pix_q};
	assign dy65      = {rpy[63], rpy} - {piy_q[63], piy_q};
	assign mx        = dx65[64] ? (64'd0 - dx65[63:0]) : dx65[63:0];
	assign my        = dy65[64] ? (64'd0 - dy65[63:0]) : dy65[63:0];
	assign pair_zero = (mx == '0) && (my == '0);
	assign norm_go   = (ux_q[63:31] != '0) || (uy_q[63:31] != '0);

	assign mul_last = (cnt_q[4:0] == 5'd31);
	assign acc_nxt  = acc_q + (mb_q[0] ? ma_q : 96'd0);

	assign tr      = res_q + bit_q;
	assign sq_ge   = (sv_q >= tr);
	assign sv_nxt  = sq_ge ? (sv_q - tr) : sv_q;
	assign res_nxt = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	assign remsh   = {rem_q, pd_q[86]};
	assign div_ge  = (remsh >= {1'b0, d_q});
	assign rem_nxt = div_ge ? 96'(remsh - {1'b0, d_q}) : remsh[95:0];

	assign q_mag = (ovf_q || q_q[63]) ? {1'b0, {63{1'b1}}} : q_q;
	assign term  = with_sign(q_mag, axis_q ? ny_q : nx_q);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_c;
	assign m_tdata  = {4'b0, vy_q, vx_q, py_q, px_q, 4'(i_q)};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			axis_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			body_count_q <= 5'd2;
			time_step_q  <= 16'd655;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					nbge_pkg::REG_BODY_COUNT: body_count_q <= cfg_wdata[4:0];
					nbge_pkg::REG_TIME_STEP:  time_step_q  <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tuser != nbge_pkg::MODE_LOAD && count_c != '0) begin
						i_q     <= '0;
						state_q <= S_A_RDI;
					end
				end
				S_A_RDI:  state_q <= S_A_LDI;
				S_A_LDI: begin
					j_q     <= '0;
					state_q <= S_A_SELJ;
				end
				S_A_SELJ: begin
					if (j_q == count_c)
						state_q <= S_A_WR;
					else if (j_q == i_q)
						j_q <= CW'(j_q + 1'b1);
					else
						state_q <= S_A_RDJ;
				end
				S_A_RDJ:  state_q <= S_A_DIFF;
				S_A_DIFF: begin
					if (pair_zero) begin
						j_q     <= CW'(j_q + 1'b1);
						state_q <= S_A_SELJ;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM:   if (!norm_go) state_q <= S_SQ1;
				S_SQ1:    if (mul_last) state_q <= S_SQ2;
				S_SQ2:    if (mul_last) state_q <= S_SQRT;
				S_SQRT:   if (mul_last) state_q <= S_R2;
				S_R2:     if (mul_last) state_q <= S_R3;
				S_R3: begin
					if (mul_last) begin
						axis_q  <= 1'b0;
						state_q <= S_MULG;
					end
				end
				S_MULG:   if (mul_last) state_q <= S_DIV;
				S_DIV:    if (cnt_q == 8'd1) state_q <= S_ACC;
				S_ACC: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_MULG;
					end else begin
						j_q     <= CW'(j_q + 1'b1);
						state_q <= S_A_SELJ;
					end
				end
				S_A_WR: begin
					if (last_c) begin
						i_q     <= '0;
						state_q <= S_B_RD;
					end else begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= S_A_RDI;
					end
				end
				S_B_RD:   state_q <= S_B_LD;
				S_B_LD:   state_q <= S_MVX;
				S_MVX:    if (mul_last) state_q <= S_MVY;
				S_MVY:    if (mul_last) state_q <= S_MPX;
				S_MPX:    if (mul_last) state_q <= S_MPY;
				S_MPY:    if (mul_last) state_q <= S_B_OUT;
				S_B_OUT: begin
					m_tvalid_q <= 1'b1;
					state_q    <= S_B_WAIT;
				end
				S_B_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (last_c) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= CW'(i_q + 1'b1);
							state_q <= S_B_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (wr_body)
			valid_q[wr_addr] <= 1'b1;
	end

	// body table and acceleration store
	always_ff @(posedge clk) begin
		if (wr_body) begin
			if (state_q == S_IDLE) begin
				body_gm_q[wr_addr] <= s_tdata[59:4];
				body_px_q[wr_addr] <= s_tdata[123:60];
				body_py_q[wr_addr] <= s_tdata[187:124];
				body_vx_q[wr_addr] <= s_tdata[251:188];
				body_vy_q[wr_addr] <= s_tdata[315:252];
			end else begin
				body_gm_q[wr_addr] <= rgm;
				body_px_q[wr_addr] <= px_q;
				body_py_q[wr_addr] <= py_q;
				body_vx_q[wr_addr] <= vx_q;
				body_vy_q[wr_addr] <= vy_q;
			end
		end
		if (state_q == S_A_WR) begin
			accel_x_q[i_q[IW-1:0]] <= accx_q;
			accel_y_q[i_q[IW-1:0]] <= accy_q;
		end
		rd_gm_q  <= body_gm_q[rd_addr];
		rd_px_q  <= body_px_q[rd_addr];
		rd_py_q  <= body_py_q[rd_addr];
		rd_vx_q  <= body_vx_q[rd_addr];
		rd_vy_q  <= body_vy_q[rd_addr];
		rd_ax_q  <= accel_x_q[rd_addr];
		rd_ay_q  <= accel_y_q[rd_addr];
		rd_vld_q <= valid_q[rd_addr];
	end

	// serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_A_LDI: begin
				pix_q  <= rpx;
				piy_q  <= rpy;
				accx_q <= '0;
				accy_q <= '0;
			end
			S_A_DIFF: begin
				ux_q <= mx;
				uy_q <= my;
				nx_q <= dx65[64];
				ny_q <= dy65[64];
				gm_q <= rgm;
				s_q  <= '0;
			end
			S_NORM: begin
				if (norm_go) begin
					ux_q <= ux_q >> 1;
					uy_q <= uy_q >> 1;
					s_q  <= s_q + 6'd1;
				end else begin
					ma_q  <= {64'd0, ux_q[31:0]};
					mb_q  <= ux_q[31:0];
					acc_q <= '0;
					cnt_q <= '0;
				end
			end
			S_SQ1, S_SQ2, S_R2, S_R3, S_MULG, S_MVX, S_MVY, S_MPX, S_MPY: begin
				acc_q <= acc_nxt;
				ma_q  <= ma_q << 1;
				mb_q  <= mb_q >> 1;
				cnt_q <= cnt_q + 8'd1;
				if (mul_last) begin
					cnt_q <= '0;
					acc_q <= '0;
					case (state_q)
						S_SQ1: begin
							acc_q <= acc_nxt;
							ma_q  <= {64'd0, uy_q[31:0]};
							mb_q  <= uy_q[31:0];
						end
						S_SQ2: begin
							sv_q  <= acc_nxt[63:0];
							res_q <= '0;
							bit_q <= 64'h4000_0000_0000_0000;
						end
						S_R2: begin
							ma_q <= {32'd0, acc_nxt[63:0]};
							mb_q <= r_q;
						end
						S_R3: begin
							d_q  <= acc_nxt;
							ma_q <= {40'd0, gm_q};
							mb_q <= ux_q[31:0];
						end
						S_MULG: begin
							pd_q  <= acc_nxt[86:0];
							rem_q <= '0;
							q_q   <= '0;
							ovf_q <= 1'b0;
							cnt_q <= 8'd151 - {1'b0, s_q, 1'b0};
						end
						S_MVX: begin
							vx_q <= sat_add(vx_q, with_sign({1'b0, acc_nxt[78:16]}, ax_q[63]));
							ma_q <= {32'd0, absv(ay_q)};
							mb_q <= {16'd0, time_step_q};
						end
						S_MVY: begin
							vy_q <= sat_add(vy_q, with_sign({1'b0, acc_nxt[78:16]}, ay_q[63]));
							ma_q <= {32'd0, absv(vx_q)};
							mb_q <= {16'd0, time_step_q};
						end
						S_MPX: begin
							px_q <= sat_add(px_q, with_sign({16'd0, acc_nxt[79:32]}, vx_q[63]));
							ma_q <= {32'd0, absv(vy_q)};
							mb_q <= {16'd0, time_step_q};
						end
						S_MPY: begin
							py_q <= sat_add(py_q, with_sign({16'd0, acc_nxt[79:32]}, vy_q[63]));
						end
						default: ;
					endcase
				end
			end
			S_SQRT: begin
				sv_q  <= sv_nxt;
				res_q <= res_nxt;
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 8'd1;
				if (mul_last) begin
					r_q   <= res_nxt[31:0];
					ma_q  <= {64'd0, res_nxt[31:0]};
					mb_q  <= res_nxt[31:0];
					acc_q <= '0;
					cnt_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= rem_nxt;
				q_q   <= {q_q[62:0], div_ge};
				ovf_q <= ovf_q | q_q[63];
				pd_q  <= pd_q << 1;
				cnt_q <= cnt_q - 8'd1;
			end
			S_ACC: begin
				if (!axis_q)
					accx_q <= sat_add(accx_q, term);
				else
					accy_q <= sat_add(accy_q, term);
				ma_q  <= {40'd0, gm_q};
				mb_q  <= uy_q[31:0];
				acc_q <= '0;
				cnt_q <= '0;
			end
			S_B_LD: begin
				px_q  <= rpx;
				py_q  <= rpy;
				vx_q  <= rvx;
				vy_q  <= rvy;
				ax_q  <= rd_ax_q;
				ay_q  <= rd_ay_q;
				ma_q  <= {32'd0, absv(rd_ax_q)};
				mb_q  <= {16'd0, time_step_q};
				acc_q <= '0;
				cnt_q <= '0;
			end
			default: ;
		endcase
	end

endmodule

// File: design/nbge_checker.sv
module nbge_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [nbge_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic                              m_tlast
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while a result is pending");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == nbge_pkg::MODE_LOAD) |=> !m_tvalid)
		else $error("load transaction produced a result");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not idle after final result");

endmodule

bind nbody_gravity_euler_step nbge_checker u_nbge_checker (.*);
